FILE: hdl/pbrq_pkg.sv
// pbrq_pkg: sizes, payload types, cell command codes and status codes
// for the bucketed priority ready queue; no dependencies
package pbrq_pkg;

   // sizing of the queue
   localparam int NUM_PRIORITIES = 16;
   localparam int CAPACITY       = 64;
   localparam int ID_BITS        = 16;

   localparam int IDX_BITS  = $clog2(CAPACITY);
   localparam int PRIO_BITS = $clog2(NUM_PRIORITIES);
   localparam int CNT_BITS  = $clog2(CAPACITY + 1);

   // fixed widths of the request and response fields
   localparam int ACTION_W   = 1;
   localparam int PRIO_W     = 4;
   localparam int PROC_ID_W  = 16;
   localparam int STATUS_W   = 2;
   localparam int OUT_ID_W   = 16;
   localparam int COUNT_W    = 7;

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [PRIO_BITS-1:0]  prio_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [ID_BITS-1:0]    id_type;

   typedef logic [ACTION_W-1:0]   action_type;
   typedef logic [PRIO_W-1:0]     prio_field_type;
   typedef logic [PROC_ID_W-1:0]  proc_id_type;
   typedef logic [STATUS_W-1:0]   status_type;
   typedef logic [OUT_ID_W-1:0]   out_id_type;
   typedef logic [COUNT_W-1:0]    count_type;

   // request actions
   localparam action_type ACT_INSERT = 1'b0;
   localparam action_type ACT_REMOVE = 1'b1;

   // response status codes
   localparam status_type ST_INSERTED = 2'd0;
   localparam status_type ST_REMOVED  = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   // commands broadcast to the bucket cells
   typedef logic [1:0] cmd_op_type;
   localparam cmd_op_type CMD_NONE   = 2'd0;
   localparam cmd_op_type CMD_INSERT = 2'd1;
   localparam cmd_op_type CMD_REMOVE = 2'd2;

   typedef struct packed {
      cmd_op_type op;
      prio_type   bucket;
      idx_type    entry;   // new head on insert
      idx_type    link;    // next head on remove
   } cell_cmd_type;

   // what one cell shows of its bucket
   typedef struct packed {
      logic    nonempty;
      idx_type head;
      cnt_type size;
   } cell_view_type;

   // lowest nonempty bucket, carried from cell to cell
   typedef struct packed {
      logic     found;
      prio_type bucket;
      idx_type  head;
      cnt_type  size;
   } chain_type;

endpackage

FILE: hdl/pbrq_ifs.sv
// pbrq_req_if and pbrq_rsp_if: valid/ready channels of the ready queue
// depends on pbrq_pkg
interface pbrq_req_if;
   import pbrq_pkg::*;

   logic           valid;
   logic           ready;
   action_type     action;
   prio_field_type priority_req;
   proc_id_type    proc_id;

   modport source (output valid, action, priority_req, proc_id, input ready);
   modport sink   (input valid, action, priority_req, proc_id, output ready);
endinterface

interface pbrq_rsp_if;
   import pbrq_pkg::*;

   logic           valid;
   logic           ready;
   status_type     status;
   out_id_type     out_id;
   prio_field_type out_priority;
   count_type      total_count;
   count_type      bucket_size;

   modport source (output valid, status, out_id, out_priority, total_count, bucket_size,
                   input ready);
   modport sink   (input valid, status, out_id, out_priority, total_count, bucket_size,
                   output ready);
endinterface

FILE: hdl/pbrq_ram.sv
// pbrq_ram: generic single-write, single-read memory with registered read
// no dependencies
module pbrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/pbrq_cell.sv
// pbrq_cell: one priority bucket (head, size, nonempty) and one link of the
// lowest-nonempty search chain; depends on pbrq_pkg
module pbrq_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  pbrq_pkg::prio_type      cell_index,
   input  pbrq_pkg::cell_cmd_type  cmd,
   input  pbrq_pkg::chain_type     chain_in,
   output pbrq_pkg::chain_type     chain_out,
   output pbrq_pkg::cell_view_type view
);
   import pbrq_pkg::*;

   logic    nonempty_ff, nonempty_in;
   idx_type head_ff, head_in;
   cnt_type size_ff, size_in;
   logic    hit;

   // pass the search along, or claim it if no earlier bucket holds entries
   always_comb begin
      if (!chain_in.found && nonempty_ff) begin
         chain_out.found  = 1'b1;
         chain_out.bucket = cell_index;
         chain_out.head   = head_ff;
         chain_out.size   = size_ff;
      end else begin
         chain_out = chain_in;
      end
   end

   assign view.nonempty = nonempty_ff;
   assign view.head     = head_ff;
   assign view.size     = size_ff;

   assign hit = (cmd.bucket == cell_index);

   // bucket update on a push or a pop
   always_comb begin
      nonempty_in = nonempty_ff;
      head_in     = head_ff;
      size_in     = size_ff;
      if (hit) begin
         unique case (cmd.op)
            CMD_INSERT: begin
               nonempty_in = 1'b1;
               head_in     = cmd.entry;
               size_in     = size_ff + cnt_type'(1);
            end
            CMD_REMOVE: begin
               if (size_ff > cnt_type'(1)) begin
                  head_in = cmd.link;
                  size_in = size_ff - cnt_type'(1);
               end else begin
                  nonempty_in = 1'b0;
                  head_in     = '0;
                  size_in     = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= 1'b0;
         head_ff     <= '0;
         size_ff     <= '0;
      end else begin
         nonempty_ff <= nonempty_in;
         head_ff     <= head_in;
         size_ff     <= size_in;
      end
   end

   // an empty bucket has no size, a full one has a head
   a_empty_size: assert property (@(posedge clock) disable iff (reset)
      !nonempty_ff |-> size_ff == '0)
      else $error("empty bucket with nonzero size");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      hit && cmd.op == CMD_REMOVE && size_ff > cnt_type'(1) |=> size_ff == $past(size_ff) - cnt_type'(1))
      else $error("bucket pop did not shrink the bucket");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      hit && cmd.op == CMD_INSERT |=> nonempty_ff && head_ff == $past(cmd.entry))
      else $error("bucket push did not set the head");

endmodule

FILE: hdl/priority_bucket_ready_queue.sv
// priority_bucket_ready_queue: top level of the bucketed ready queue
// depends on pbrq_pkg, pbrq_ifs, pbrq_ram, pbrq_cell
//
//  channel  direction  handshake      payload
//  req      in         valid/ready    action, priority_req, proc_id
//  rsp      out        valid/ready    status, out_id, out_priority, total_count, bucket_size
//
// A request passes through S_IDLE, which reads the link and id memories at the free
// head (insert) or at the head of the lowest nonempty bucket (remove), and S_FINISH,
// which writes them back and updates the bucket cells. A request is taken while a
// response still waits; S_FINISH holds until the response register is free.
// Reset is synchronous; link entries start from per-entry valid bits, so there is
// no clearing pass.
module priority_bucket_ready_queue (
   input logic clock,
   input logic reset,
   pbrq_req_if.sink   req,
   pbrq_rsp_if.source rsp
);
   import pbrq_pkg::*;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_FINISH = 1'b1;

   // entry index outside the store reads as entry 0
   function automatic idx_type slot_ok(input idx_type s);
      if ({1'b0, s} < (IDX_BITS + 1)'(CAPACITY)) begin
         return s;
      end
      return '0;
   endfunction

   // initial free chain: entry i links to i+1, the last one to 0
   function automatic idx_type link_init(input idx_type e);
      logic [IDX_BITS:0] nxt;
      nxt = {1'b0, e} + (IDX_BITS + 1)'(1);
      if (nxt < (IDX_BITS + 1)'(CAPACITY)) begin
         return idx_type'(nxt);
      end
      return '0;
   endfunction

   // bucket for an insert, saturated to the last bucket
   function automatic prio_type sat_prio(input prio_field_type p);
      if (32'(p) >= NUM_PRIORITIES) begin
         return prio_type'(NUM_PRIORITIES - 1);
      end
      return prio_type'(p);
   endfunction

   logic          state_ff, state_in;
   action_type    act_ff;
   prio_type      pr_ff;
   id_type        pid_ff;
   idx_type       entry_ff;
   chain_type     pick_ff;
   logic          full_ff;
   logic          lv_ff;
   idx_type       link_init_ff;

   idx_type       free_head_ff, free_head_in;
   cnt_type       total_ff, total_in;
   logic [CAPACITY-1:0] link_valid_ff, link_valid_in;

   logic          rsp_valid_ff;
   status_type    rsp_status_ff, rsp_status_in;
   out_id_type    rsp_id_ff, rsp_id_in;
   prio_field_type rsp_prio_ff, rsp_prio_in;
   count_type     rsp_total_ff;
   count_type     rsp_size_ff, rsp_size_in;

   logic          accept, go;
   idx_type       rd_addr;
   idx_type       link_q, link_rd;
   id_type        id_q;
   logic          link_we, id_we;
   idx_type       link_wdata;
   cell_cmd_type  cmd;
   cell_view_type view [NUM_PRIORITIES];
   chain_type     chain [NUM_PRIORITIES + 1];
   cell_view_type tgt;
   logic [NUM_PRIORITIES-1:0] nonempty_vec;

   // row of bucket cells with the search chain running from bucket 0 upward
   assign chain[0] = '0;

   for (genvar g = 0; g < NUM_PRIORITIES; g++) begin : g_bucket
      pbrq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (prio_type'(g)),
         .cmd        (cmd),
         .chain_in   (chain[g]),
         .chain_out  (chain[g+1]),
         .view       (view[g])
      );
      assign nonempty_vec[g] = view[g].nonempty;
   end

   // link and id stores, shared by all buckets
   pbrq_ram #(.WIDTH(IDX_BITS), .DEPTH(CAPACITY)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (entry_ff),
      .wr_data (link_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (link_q)
   );

   pbrq_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (entry_ff),
      .wr_data (pid_ff),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (id_q)
   );

   // request side
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign rd_addr   = (req.action == ACT_INSERT) ? slot_ok(free_head_ff)
                                                 : slot_ok(chain[NUM_PRIORITIES].head);

   // the finish state proceeds once the response register can take a result
   assign go      = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp.ready);
   assign tgt     = view[pr_ff];
   assign link_rd = lv_ff ? link_q : link_init_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = S_FINISH;
         S_FINISH: if (go)     state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // write-back, bucket command and response of the finish state
   always_comb begin
      free_head_in  = free_head_ff;
      total_in      = total_ff;
      link_valid_in = link_valid_ff;
      link_we       = 1'b0;
      id_we         = 1'b0;
      link_wdata    = '0;
      cmd           = '0;
      rsp_status_in = ST_EMPTY;
      rsp_id_in     = '0;
      rsp_prio_in   = '0;
      rsp_size_in   = '0;
      if (go) begin
         priority if (act_ff == ACT_INSERT && full_ff) begin
            rsp_status_in = ST_FULL;
            rsp_prio_in   = PRIO_W'(pr_ff);
            rsp_size_in   = COUNT_W'(tgt.size);
         end else if (act_ff == ACT_INSERT) begin
            id_we         = 1'b1;
            link_we       = 1'b1;
            link_wdata    = tgt.nonempty ? tgt.head : '0;
            link_valid_in[entry_ff] = 1'b1;
            free_head_in  = slot_ok(link_rd);
            total_in      = total_ff + cnt_type'(1);
            cmd.op        = CMD_INSERT;
            cmd.bucket    = pr_ff;
            cmd.entry     = entry_ff;
            rsp_status_in = ST_INSERTED;
            rsp_prio_in   = PRIO_W'(pr_ff);
            rsp_size_in   = COUNT_W'(tgt.size + cnt_type'(1));
         end else if (pick_ff.found) begin
            link_we       = 1'b1;
            link_wdata    = free_head_ff;
            link_valid_in[entry_ff] = 1'b1;
            free_head_in  = entry_ff;
            if (total_ff != '0) total_in = total_ff - cnt_type'(1);
            cmd.op        = CMD_REMOVE;
            cmd.bucket    = pick_ff.bucket;
            cmd.link      = slot_ok(link_rd);
            rsp_status_in = ST_REMOVED;
            rsp_id_in     = OUT_ID_W'(id_q);
            rsp_prio_in   = PRIO_W'(pick_ff.bucket);
            rsp_size_in   = (pick_ff.size > cnt_type'(1)) ?
                            COUNT_W'(pick_ff.size - cnt_type'(1)) : '0;
         end else begin
            rsp_status_in = ST_EMPTY;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_head_ff  <= '0;
         total_ff      <= '0;
         link_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         total_ff      <= total_in;
         link_valid_ff <= link_valid_in;
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff       <= req.action;
         pr_ff        <= sat_prio(req.priority_req);
         pid_ff       <= id_type'(req.proc_id);
         entry_ff     <= rd_addr;
         pick_ff      <= chain[NUM_PRIORITIES];
         full_ff      <= (total_ff >= cnt_type'(CAPACITY));
         lv_ff        <= link_valid_ff[rd_addr];
         link_init_ff <= link_init(rd_addr);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_total_ff  <= COUNT_W'(total_in);
         rsp_size_ff   <= rsp_size_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.out_id       = rsp_id_ff;
   assign rsp.out_priority = rsp_prio_ff;
   assign rsp.total_count  = rsp_total_ff;
   assign rsp.bucket_size  = rsp_size_ff;

   a_accept_finish: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_FINISH)
      else $error("accepted request did not reach the second cycle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("response raised outside the second cycle");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= cnt_type'(CAPACITY))
      else $error("total count beyond capacity");

   a_total_empty: assert property (@(posedge clock) disable iff (reset)
      (total_ff == '0) == (nonempty_vec == '0))
      else $error("total count disagrees with bucket occupancy");

endmodule
